### rtl/itrd_pkg.sv
// Shared constants and types of the integer-to-radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

    localparam int VALUE_BITS   = 31;
    localparam int MAX_RADIX    = 16;
    localparam int DIGIT_BITS   = 4;
    localparam int RADIX_BITS   = DIGIT_BITS + 1;
    localparam int CHAR_BITS    = 8;
    localparam int ALPHA_BITS   = 64;
    localparam int COUNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_HIGH = 2'd2;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET      = 5'd10;
    localparam logic [ALPHA_BITS-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
    localparam logic [ALPHA_BITS-1:0] ALPHA_HIGH_RESET = 64'h4645444342413938;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

### rtl/itrd_divider.sv
// Bit-serial restoring divider of the value by the radix, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module itrd_divider (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [itrd_pkg::VALUE_BITS-1:0]     dividend,
    input  wire logic [itrd_pkg::RADIX_BITS-1:0]     radix,
    output logic      [itrd_pkg::VALUE_BITS-1:0]     quotient,
    output logic      [itrd_pkg::DIGIT_BITS-1:0]     remainder,
    output itrd_pkg::div_status_t                    status
);

    localparam logic [itrd_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
        itrd_pkg::DIV_CNT_BITS'(itrd_pkg::VALUE_BITS - 1);

    logic [itrd_pkg::VALUE_BITS-1:0]   q_reg;
    logic [itrd_pkg::DIGIT_BITS-1:0]   rem_reg;
    logic [itrd_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic                              running_reg;
    logic                              done_reg;

    logic [itrd_pkg::RADIX_BITS-1:0] shifted;
    logic [itrd_pkg::RADIX_BITS-1:0] diff;
    logic                            ge;
    logic [itrd_pkg::DIGIT_BITS-1:0] rem_next;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    assign shifted  = {rem_reg, q_reg[itrd_pkg::VALUE_BITS-1]};
    assign ge       = (shifted >= radix);
    assign diff     = shifted - radix;
    assign rem_next = ge ? diff[itrd_pkg::DIGIT_BITS-1:0]
                         : shifted[itrd_pkg::DIGIT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else if (start) begin
            running_reg <= 1'b1;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else if (running_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                running_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end else if (running_reg) begin
            q_reg   <= {q_reg[itrd_pkg::VALUE_BITS-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient    = q_reg;
    assign remainder   = rem_reg;
    assign status.busy = running_reg | done_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

### rtl/itrd_stack.sv
// Digit stack: remainders come in least significant first and leave most significant first.
`timescale 1ns / 1ps
`default_nettype none

module itrd_stack (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                push,
    input  wire logic                                pop,
    input  wire logic [itrd_pkg::DIGIT_BITS-1:0]     push_data,
    output logic      [itrd_pkg::DIGIT_BITS-1:0]     top_data,
    output logic      [itrd_pkg::COUNT_BITS-1:0]     count
);

    logic [itrd_pkg::DIGIT_BITS-1:0] stack_reg [itrd_pkg::VALUE_BITS];
    logic [itrd_pkg::COUNT_BITS-1:0] count_reg;

    // Entry zero is the top; a push moves every entry one place down.
    always_ff @(posedge aclk) begin
        if (push) begin
            for (int i = 1; i < itrd_pkg::VALUE_BITS; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
            stack_reg[0] <= push_data;
        end else if (pop) begin
            for (int i = 0; i < itrd_pkg::VALUE_BITS - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (push) begin
            count_reg <= count_reg + 1'b1;
        end else if (pop) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    assign top_data = stack_reg[0];
    assign count    = count_reg;

endmodule

`default_nettype wire

### rtl/integer_to_radix_digits_unit.sv
// Top level of the integer-to-radix digit converter.
//
// An unsigned value arrives on the s_ channel (valid/ready). Its digits in the
// configured radix leave on the m_ channel, one transaction per digit, most
// significant first, each with its alphabet character; m_last_digit marks the
// least significant digit. Zero gives a single digit.
// The value is divided by the radix repeatedly in a bit-serial divider, one
// quotient bit per cycle, and all digits are divided out before any is emitted.
// The remainders are kept on a digit stack to reverse their order.
// When the receiver stalls, the output register holds its digit and emission
// waits; a new value is accepted as soon as the last digit sits in the output
// register. Reset (aresetn, synchronous, active low) empties the block and
// restores radix 10 with the alphabet "0123456789ABCDEF".
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle; the
// user must keep to this, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [itrd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [itrd_pkg::ALPHA_BITS-1:0]     cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [itrd_pkg::VALUE_BITS-1:0]     s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [itrd_pkg::CHAR_BITS-1:0]      m_digit_char,
    output logic      [itrd_pkg::DIGIT_BITS-1:0]     m_digit_value,
    output logic                                     m_last_digit
);

    localparam logic [itrd_pkg::RADIX_BITS-1:0] MIN_RADIX_C = itrd_pkg::RADIX_BITS'(2);
    localparam logic [itrd_pkg::RADIX_BITS-1:0] MAX_RADIX_C =
        itrd_pkg::RADIX_BITS'(itrd_pkg::MAX_RADIX);
    localparam logic [itrd_pkg::COUNT_BITS-1:0] ONE_DIGIT = itrd_pkg::COUNT_BITS'(1);

    logic [itrd_pkg::RADIX_BITS-1:0] radix_reg;
    logic [itrd_pkg::ALPHA_BITS-1:0] alpha_low_reg;
    logic [itrd_pkg::ALPHA_BITS-1:0] alpha_high_reg;
    logic [itrd_pkg::RADIX_BITS-1:0] eff_radix;

    itrd_pkg::state_t state_reg;
    itrd_pkg::state_t state_next;

    logic                            div_start;
    logic [itrd_pkg::VALUE_BITS-1:0] div_dividend;
    logic [itrd_pkg::VALUE_BITS-1:0] div_quotient;
    logic [itrd_pkg::DIGIT_BITS-1:0] div_remainder;
    itrd_pkg::div_status_t           div_status;
    logic                            quotient_zero;

    logic                            stack_push;
    logic                            stack_pop;
    logic [itrd_pkg::DIGIT_BITS-1:0] stack_top;
    logic [itrd_pkg::COUNT_BITS-1:0] stack_count;

    logic                            out_free;
    logic [itrd_pkg::ALPHA_BITS-1:0] alpha_word;

    logic                            m_valid_reg;
    logic [itrd_pkg::CHAR_BITS-1:0]  m_char_reg;
    logic [itrd_pkg::DIGIT_BITS-1:0] m_value_reg;
    logic                            m_last_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= itrd_pkg::RADIX_RESET;
            alpha_low_reg  <= itrd_pkg::ALPHA_LOW_RESET;
            alpha_high_reg <= itrd_pkg::ALPHA_HIGH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                itrd_pkg::CFG_RADIX: begin
                    radix_reg <= cfg_wdata[itrd_pkg::RADIX_BITS-1:0];
                end
                itrd_pkg::CFG_ALPHA_LOW: begin
                    alpha_low_reg <= cfg_wdata;
                end
                itrd_pkg::CFG_ALPHA_HIGH: begin
                    alpha_high_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (radix_reg < MIN_RADIX_C) begin
            eff_radix = MIN_RADIX_C;
        end else if (radix_reg > MAX_RADIX_C) begin
            eff_radix = MAX_RADIX_C;
        end else begin
            eff_radix = radix_reg;
        end
    end

    assign quotient_zero = (div_quotient == '0);
    assign out_free      = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            itrd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = itrd_pkg::ST_DIVIDE;
                end
            end
            itrd_pkg::ST_DIVIDE: begin
                if (div_status.done && quotient_zero) begin
                    state_next = itrd_pkg::ST_EMIT;
                end
            end
            itrd_pkg::ST_EMIT: begin
                if (out_free && stack_count == ONE_DIGIT) begin
                    state_next = itrd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itrd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_quotient;
        stack_push   = 1'b0;
        stack_pop    = 1'b0;
        unique case (state_reg)
            itrd_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                div_start    = s_valid;
                div_dividend = s_value;
            end
            itrd_pkg::ST_DIVIDE: begin
                stack_push = div_status.done;
                // A non-zero quotient still has digits above this one.
                div_start  = div_status.done && !quotient_zero;
            end
            itrd_pkg::ST_EMIT: begin
                stack_pop = out_free && (stack_count != '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itrd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    itrd_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (eff_radix),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_status)
    );

    itrd_stack u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (stack_push),
        .pop       (stack_pop),
        .push_data (div_remainder),
        .top_data  (stack_top),
        .count     (stack_count)
    );

    assign alpha_word = stack_top[itrd_pkg::DIGIT_BITS-1] ? alpha_high_reg : alpha_low_reg;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stack_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_pop) begin
            m_value_reg <= stack_top;
            m_char_reg  <= alpha_word[{stack_top[itrd_pkg::DIGIT_BITS-2:0], 3'b000} +:
                                      itrd_pkg::CHAR_BITS];
            m_last_reg  <= (stack_count == ONE_DIGIT);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_digit_char  = m_char_reg;
    assign m_digit_value = m_value_reg;
    assign m_last_digit  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stack_count <= itrd_pkg::COUNT_BITS'(itrd_pkg::VALUE_BITS))
        else $error("digit stack holds more digits than a value can have");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itrd_pkg::ST_IDLE) |-> (stack_count == '0))
        else $error("digit stack not empty while idle");

    a_div_only_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == itrd_pkg::ST_DIVIDE))
        else $error("divider active outside the divide phase");

    a_emit_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itrd_pkg::ST_EMIT) |-> (stack_count != '0))
        else $error("emit phase entered with no digits");
`endif

endmodule

`default_nettype wire
